// ===== rtl/core/utf8ds_pkg.sv =====
package utf8ds_pkg;

    // code point constants
    localparam logic [20:0] REPL_CP    = 21'h00FFFD;
    localparam logic [20:0] MAX_CP     = 21'h10FFFF;
    localparam logic [20:0] SURR_LO    = 21'h00D800;
    localparam logic [20:0] SURR_HI    = 21'h00DFFF;
    localparam logic [20:0] NONCHAR_LO = 21'h00FDD0;
    localparam logic [20:0] NONCHAR_HI = 21'h00FDEF;
    localparam logic [20:0] C0_HI      = 21'h00001F;
    localparam logic [20:0] DEL_CP     = 21'h00007F;
    localparam logic [20:0] C1_HI      = 21'h00009F;
    localparam logic [20:0] TAB_CP     = 21'h000009;
    localparam logic [20:0] LF_CP      = 21'h00000A;
    localparam logic [20:0] CR_CP      = 21'h00000D;

    // shortest legal value per sequence length
    localparam logic [20:0] MIN_TWO    = 21'h000080;
    localparam logic [20:0] MIN_THREE  = 21'h000800;
    localparam logic [20:0] MIN_FOUR   = 21'h010000;

    // continuation bytes a pending sequence needs
    localparam logic [1:0] SEQ_NONE  = 2'd0;
    localparam logic [1:0] SEQ_TWO   = 2'd1;
    localparam logic [1:0] SEQ_THREE = 2'd2;
    localparam logic [1:0] SEQ_FOUR  = 2'd3;

    // results caused by one input byte: count-1 replacements, then cp
    typedef struct packed {
        logic [2:0]  count;
        logic [20:0] cp;
        logic        fin;
    } bundle_t;

    // replace out-of-range, surrogate, noncharacter and control values (tab, LF and CR are kept)
    function automatic logic [20:0] sanitize(input logic [20:0] cp);
        logic bad;
        logic ctrl;
        logic keep;
        ctrl = (cp <= C0_HI) || ((cp >= DEL_CP) && (cp <= C1_HI));
        keep = (cp == TAB_CP) || (cp == LF_CP) || (cp == CR_CP);
        bad  = (cp > MAX_CP)
            || ((cp >= SURR_LO) && (cp <= SURR_HI))
            || ((cp >= NONCHAR_LO) && (cp <= NONCHAR_HI))
            || (cp[15:1] == 15'h7FFF)
            || (ctrl && !keep);
        return bad ? REPL_CP : cp;
    endfunction

endpackage

// ===== rtl/core/utf8ds_decode.sv =====
module utf8ds_decode
    import utf8ds_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output bundle_t    bundle
);

    logic [20:0] pv_reg;
    logic [20:0] pv_next;
    logic [1:0]  need_reg;
    logic [1:0]  need_next;
    logic [1:0]  recv_reg;
    logic [1:0]  recv_next;

    // decode one byte against the pending sequence
    always_comb
    begin
        logic        cont;
        logic [2:0]  got;
        logic [2:0]  pre;
        logic [20:0] pv_shift;
        logic [20:0] low;

        cont     = (data_byte[7:6] == 2'b10);
        got      = {1'b0, recv_reg} + 3'd1;
        pv_shift = {pv_reg[14:0], data_byte[5:0]};

        unique case (need_reg)
            SEQ_TWO:   low = MIN_TWO;
            SEQ_THREE: low = MIN_THREE;
            SEQ_FOUR:  low = MIN_FOUR;
            default:   low = MIN_TWO;
        endcase

        pv_next      = pv_reg;
        need_next    = need_reg;
        recv_next    = recv_reg;
        bundle.count = 3'd0;
        bundle.cp    = REPL_CP;
        bundle.fin   = final_byte;
        pre          = 3'd0;

        if ((need_reg != SEQ_NONE) && cont)
        begin
            if (got >= {1'b0, need_reg})
            begin
                // sequence complete, reject overlong forms
                bundle.count = 3'd1;
                bundle.cp    = (pv_shift < low) ? REPL_CP : sanitize(pv_shift);
                pv_next      = '0;
                need_next    = SEQ_NONE;
                recv_next    = '0;
            end
            else if (!final_byte)
            begin
                pv_next   = pv_shift;
                recv_next = got[1:0];
            end
            else
            begin
                // text ends mid-sequence: lead plus each continuation
                bundle.count = got + 3'd1;
                pv_next      = '0;
                need_next    = SEQ_NONE;
                recv_next    = '0;
            end
        end
        else
        begin
            // flush an interrupted sequence, then decode the byte afresh
            if (need_reg != SEQ_NONE)
                pre = got;
            pv_next   = '0;
            need_next = SEQ_NONE;
            recv_next = '0;
            if (!data_byte[7])
            begin
                bundle.count = pre + 3'd1;
                bundle.cp    = sanitize({13'd0, data_byte});
            end
            else if ((data_byte[7:5] == 3'b110) || (data_byte[7:4] == 4'b1110)
                     || (data_byte[7:3] == 5'b11110))
            begin
                if (final_byte)
                begin
                    bundle.count = pre + 3'd1;
                end
                else
                begin
                    bundle.count = pre;
                    if (data_byte[7:5] == 3'b110)
                    begin
                        need_next = SEQ_TWO;
                        pv_next   = {16'd0, data_byte[4:0]};
                    end
                    else if (data_byte[7:4] == 4'b1110)
                    begin
                        need_next = SEQ_THREE;
                        pv_next   = {17'd0, data_byte[3:0]};
                    end
                    else
                    begin
                        need_next = SEQ_FOUR;
                        pv_next   = {18'd0, data_byte[2:0]};
                    end
                end
            end
            else
            begin
                // stray continuation or invalid lead
                bundle.count = pre + 3'd1;
            end
        end
    end

    // sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg   <= '0;
            need_reg <= SEQ_NONE;
            recv_reg <= '0;
        end
        else if (accept)
        begin
            pv_reg   <= pv_next;
            need_reg <= need_next;
            recv_reg <= recv_next;
        end
    end

endmodule

// ===== rtl/core/utf8ds_emit.sv =====
module utf8ds_emit
    import utf8ds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  bundle_t     bundle,
    output logic        busy,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [20:0] code_point,
    output logic        run_last,
    output logic        text_end
);

    logic        bnd_valid_reg;
    logic        bnd_valid_next;
    bundle_t     bnd_reg;
    bundle_t     bnd_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [20:0] cp_reg;
    logic [20:0] cp_next;
    logic        last_reg;
    logic        last_next;
    logic        end_reg;
    logic        end_next;
    logic        out_free;
    logic        emit;
    logic        done;

    // result handshake and buffer control
    assign out_free = !out_valid_reg || !out_stall;
    assign emit     = bnd_valid_reg && out_free;
    assign done     = emit && (bnd_reg.count == 3'd1);
    assign busy     = bnd_valid_reg && !done;

    // serialize buffered results: replacements first, decoded value last
    always_comb
    begin
        bnd_valid_next = bnd_valid_reg;
        bnd_next       = bnd_reg;
        out_valid_next = out_valid_reg;
        cp_next        = cp_reg;
        last_next      = last_reg;
        end_next       = end_reg;

        if (out_free)
        begin
            out_valid_next = bnd_valid_reg;
            if (bnd_reg.count == 3'd1)
            begin
                cp_next   = bnd_reg.cp;
                last_next = 1'b1;
                end_next  = bnd_reg.fin;
            end
            else
            begin
                cp_next   = REPL_CP;
                last_next = 1'b0;
                end_next  = 1'b0;
            end
        end

        if (push && (bundle.count != 3'd0))
        begin
            bnd_valid_next = 1'b1;
            bnd_next       = bundle;
        end
        else if (done)
        begin
            bnd_valid_next = 1'b0;
        end
        else if (emit)
        begin
            bnd_next.count = bnd_reg.count - 3'd1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bnd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bnd_valid_reg <= bnd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        bnd_reg  <= bnd_next;
        cp_reg   <= cp_next;
        last_reg <= last_next;
        end_reg  <= end_next;
    end

    assign out_valid  = out_valid_reg;
    assign code_point = cp_reg;
    assign run_last   = last_reg;
    assign text_end   = end_reg;

endmodule

// ===== rtl/core/utf8_decode_sanitize.sv =====
// UTF-8 decoder with sanitizer. One text byte per request in, one code point
// per request out; run_last flags the last result a byte caused and text_end
// the last result of the text. A byte is taken every cycle while each byte
// yields at most one result and out_stall is low. A byte that yields n
// results (up to four, on errors) holds the single-entry result buffer
// until the output register has taken all n, one per cycle while out_stall
// is low; each result passes through the buffer, then the output register.
// Replacement results always precede the decoded value of the same byte.
module utf8_decode_sanitize
    import utf8ds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [20:0] code_point,
    output logic        run_last,
    output logic        text_end
);

    logic    in_accept;
    logic    busy;
    bundle_t bundle;

    // input handshake
    assign in_accept = in_valid && !in_stall;
    assign in_stall  = busy;

    // byte decoder and sequence state
    utf8ds_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_accept),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .bundle     (bundle)
    );

    // result buffer and output register
    utf8ds_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_accept),
        .bundle     (bundle),
        .busy       (busy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .code_point (code_point),
        .run_last   (run_last),
        .text_end   (text_end)
    );

`ifndef ASSERT_OFF
    // end of text always closes a byte's run
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && text_end) |-> run_last)
    else $error("text_end without run_last");

    // results ahead of the last one of a byte are replacements
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !run_last) |-> (code_point == REPL_CP))
    else $error("non-final result is not a replacement");

    // sanitized output never leaves the code space
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (code_point <= MAX_CP))
    else $error("code point out of range");
`endif

endmodule
